[rtl/efd_pkg.sv]
// Shared types, constants and helper functions for the escaped frame deframer.
// No dependencies; every other file imports this package.
`default_nettype none

package efd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 14;
    localparam int HALF_W   = 7;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Default depth of the queue between classifier and frame engine.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values.
    localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd254;
    localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd255;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd253;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CODE  = 2'd0,
        CFG_END_CODE    = 2'd1,
        CFG_ESCAPE_CODE = 2'd2
    } cfg_idx_t;

    // Byte class found by the front end.
    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_END   = 2'd1,
        CLS_ESC   = 2'd2,
        CLS_DATA  = 2'd3
    } cls_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OUTSIDE       = 3'd0,
        ERR_BAD_ESCAPE    = 3'd1,
        ERR_TOO_LONG      = 3'd2,
        ERR_STRAY_END     = 3'd3,
        ERR_RESTART       = 3'd4,
        ERR_DOUBLE_ESCAPE = 3'd5,
        ERR_EARLY_END     = 3'd6
    } err_t;

    // Header progress of the open frame.
    typedef enum logic [1:0] {
        HDR_HIGH    = 2'd0,
        HDR_LOW     = 2'd1,
        HDR_PAYLOAD = 2'd2
    } hdr_phase_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        cls_t              cls;
        logic [BYTE_W-1:0] data;
    } efd_item_t;

    // Number of escape indexes that map to a reserved byte.
    localparam logic [BYTE_W-1:0] RESERVED_COUNT = 8'd3;

    // Reserved byte for an escape index 0..2.
    function automatic logic [BYTE_W-1:0] unescape_index(input logic [1:0] idx);
        logic [BYTE_W-1:0] val;
        case (idx)
            2'd0:    val = 8'd253;
            2'd1:    val = 8'd254;
            2'd2:    val = 8'd255;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/efd_front.sv]
// Front end: holds the code registers and classifies each received byte.
// Depends on efd_pkg.
`default_nettype none

module efd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]   cfg_data,
    input  wire logic [efd_pkg::BYTE_W-1:0]   rx_byte,
    output efd_pkg::efd_item_t                item
);
    import efd_pkg::*;

    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic [BYTE_W-1:0] escape_code_reg;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_CODE_RST;
            end_code_reg    <= END_CODE_RST;
            escape_code_reg <= ESCAPE_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_CODE:  start_code_reg  <= cfg_data;
                CFG_END_CODE:    end_code_reg    <= cfg_data;
                CFG_ESCAPE_CODE: escape_code_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Classification; start wins over end, end over escape.
    always_comb
    begin
        item.data = rx_byte;
        if (rx_byte == start_code_reg)
        begin
            item.cls = CLS_START;
        end
        else if (rx_byte == end_code_reg)
        begin
            item.cls = CLS_END;
        end
        else if (rx_byte == escape_code_reg)
        begin
            item.cls = CLS_ESC;
        end
        else
        begin
            item.cls = CLS_DATA;
        end
    end

endmodule

`default_nettype wire

[rtl/efd_queue.sv]
// Short queue of classified items between the front end and the frame engine.
// Depends on efd_pkg.
`default_nettype none

module efd_queue #(
    parameter int DEPTH = efd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire efd_pkg::efd_item_t  push_item,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output efd_pkg::efd_item_t       pop_item
);
    import efd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    efd_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage array; entries carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count never runs past the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    // Nothing is taken from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    // A lone push raises the count by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

[rtl/efd_back.sv]
// Frame engine: tracks frame, header and escape state and registers results.
// Depends on efd_pkg.
`default_nettype none

module efd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire efd_pkg::efd_item_t          q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [efd_pkg::KIND_W-1:0]       kind,
    output logic [efd_pkg::BYTE_W-1:0]       byte_value,
    output logic [efd_pkg::LEN_W-1:0]        position,
    output logic [efd_pkg::ERR_W-1:0]        fault_code
);
    import efd_pkg::*;

    // Frame state.
    logic              in_frame_reg;
    logic              in_frame_next;
    logic              esc_pend_reg;
    logic              esc_pend_next;
    hdr_phase_t        hdr_reg;
    hdr_phase_t        hdr_next;
    logic [HALF_W-1:0] hi_len_reg;
    logic [HALF_W-1:0] hi_len_next;
    logic [LEN_W-1:0]  decl_len_reg;
    logic [LEN_W-1:0]  decl_len_next;
    logic [LEN_W-1:0]  byte_cnt_reg;
    logic [LEN_W-1:0]  byte_cnt_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             kind_reg;
    kind_t             res_kind;
    logic [BYTE_W-1:0] value_reg;
    logic [BYTE_W-1:0] res_value;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  res_pos;
    err_t              err_reg;
    err_t              res_err;
    logic              res_valid;

    logic              bad_index;
    logic [BYTE_W-1:0] payload_byte;

    // Take the next item whenever the output register is free or draining.
    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    assign bad_index    = (q_item.data >= RESERVED_COUNT);
    assign payload_byte = esc_pend_reg ? unescape_index(q_item.data[1:0]) : q_item.data;

    // Next frame state for the item at the head of the queue.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        hdr_next      = hdr_reg;
        hi_len_next   = hi_len_reg;
        decl_len_next = decl_len_reg;
        byte_cnt_next = byte_cnt_reg;
        if (q_pop)
        begin
            case (q_item.cls)
                CLS_START:
                begin
                    in_frame_next = 1'b1;
                    hdr_next      = HDR_HIGH;
                    byte_cnt_next = '0;
                    esc_pend_next = 1'b0;
                end
                CLS_END:
                begin
                    in_frame_next = 1'b0;
                end
                CLS_ESC:
                begin
                    if (in_frame_reg)
                    begin
                        esc_pend_next = 1'b1;
                        if (esc_pend_reg)
                        begin
                            in_frame_next = 1'b0;
                        end
                    end
                end
                CLS_DATA:
                begin
                    if (in_frame_reg)
                    begin
                        if (hdr_reg == HDR_HIGH)
                        begin
                            hi_len_next = q_item.data[HALF_W-1:0];
                            hdr_next    = HDR_LOW;
                        end
                        else if (hdr_reg == HDR_LOW)
                        begin
                            decl_len_next = {hi_len_reg, q_item.data[HALF_W-1:0]};
                            hdr_next      = HDR_PAYLOAD;
                        end
                        else
                        begin
                            esc_pend_next = 1'b0;
                            if (esc_pend_reg && bad_index)
                            begin
                                in_frame_next = 1'b0;
                            end
                            else if (byte_cnt_reg >= decl_len_reg)
                            begin
                                in_frame_next = 1'b0;
                            end
                            else
                            begin
                                byte_cnt_next = byte_cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result for the item at the head of the queue.
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = KIND_ERR;
        res_value = '0;
        res_pos   = '0;
        res_err   = ERR_OUTSIDE;
        case (q_item.cls)
            CLS_START:
            begin
                res_valid = in_frame_reg;
                res_err   = ERR_RESTART;
            end
            CLS_END:
            begin
                res_valid = 1'b1;
                if (!in_frame_reg)
                begin
                    res_err = ERR_STRAY_END;
                end
                else if (hdr_reg == HDR_PAYLOAD && byte_cnt_reg == decl_len_reg)
                begin
                    res_kind = KIND_DONE;
                    res_pos  = decl_len_reg;
                end
                else
                begin
                    res_err = ERR_EARLY_END;
                end
            end
            CLS_ESC:
            begin
                if (!in_frame_reg)
                begin
                    res_valid = 1'b1;
                end
                else if (esc_pend_reg)
                begin
                    res_valid = 1'b1;
                    res_err   = ERR_DOUBLE_ESCAPE;
                end
            end
            CLS_DATA:
            begin
                if (!in_frame_reg)
                begin
                    res_valid = 1'b1;
                end
                else if (hdr_reg == HDR_PAYLOAD)
                begin
                    res_valid = 1'b1;
                    if (esc_pend_reg && bad_index)
                    begin
                        res_err = ERR_BAD_ESCAPE;
                    end
                    else if (byte_cnt_reg >= decl_len_reg)
                    begin
                        res_err = ERR_TOO_LONG;
                    end
                    else
                    begin
                        res_kind  = KIND_BYTE;
                        res_value = payload_byte;
                        res_pos   = byte_cnt_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // The output register loads on a pop and drains when taken.
    assign out_valid_next = q_pop ? res_valid : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            esc_pend_reg  <= 1'b0;
            hdr_reg       <= HDR_HIGH;
            hi_len_reg    <= '0;
            decl_len_reg  <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            esc_pend_reg  <= esc_pend_next;
            hdr_reg       <= hdr_next;
            hi_len_reg    <= hi_len_next;
            decl_len_reg  <= decl_len_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (q_pop && res_valid)
        begin
            kind_reg  <= res_kind;
            value_reg <= res_value;
            pos_reg   <= res_pos;
            err_reg   <= res_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign byte_value = value_reg;
    assign position   = pos_reg;
    assign fault_code = err_reg;

    // The payload count never passes the declared length.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg <= decl_len_reg)
        else $error("byte count exceeds declared length");

    // A payload byte result always lies inside the declared length.
    a_byte_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && res_valid && res_kind == KIND_BYTE) |=> (pos_reg < decl_len_reg))
        else $error("payload position outside declared length");

    // A waiting result is never overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !q_pop)
        else $error("result overwritten while stalled");

    // Error codes only accompany error results.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_ERR) |-> (err_reg == ERR_OUTSIDE))
        else $error("nonzero error code on a non-error result");

endmodule

`default_nettype wire

[rtl/escaped_frame_deframer.sv]
// Top level of the escaped frame deframer: classifier, queue and frame engine.
// Depends on efd_pkg, efd_front, efd_queue and efd_back.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ------------------------------------------
//   input     in_valid / in_stall   rx_byte
//   output    out_valid/out_stall   kind, byte_value, position, fault_code
//   config    cfg_we                cfg_index, cfg_data
//
// One item is accepted per cycle while the queue has room; its result, if any,
// follows the item through the queue write, then the result register. The frame
// engine settles one item per cycle unless a held result is stalled; this sets the rate.
// Reset (rst_n low, asynchronous) empties the queue, closes any frame and
// restores the default codes. A stalled output holds its result; the queue
// absorbs up to QUEUE_DEPTH items before in_stall rises.
`default_nettype none

module escaped_frame_deframer #(
    parameter int QUEUE_DEPTH = efd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [efd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [efd_pkg::KIND_W-1:0]         kind,
    output logic [efd_pkg::BYTE_W-1:0]         byte_value,
    output logic [efd_pkg::LEN_W-1:0]          position,
    output logic [efd_pkg::ERR_W-1:0]          fault_code
);
    import efd_pkg::*;

    efd_item_t front_item;
    efd_item_t head_item;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      q_push;

    // Input side stalls only when the queue is full.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    efd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx_byte),
        .item      (front_item)
    );

    efd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (head_item)
    );

    efd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .byte_value (byte_value),
        .position   (position),
        .fault_code (fault_code)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for escaped_frame_deframer: directed and random byte streams.
// Depends on efd_pkg and the RTL; an internal deframer predictor supplies the expected results.
`timescale 1ns / 1ps

module tb_top;
    import efd_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_FIXED
    } row_chk_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [LEN_W-1:0]   position;
        err_t               fault_code;
    } frame_res_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  rx;
        row_chk_t           chk;
        frame_res_t         res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     kind;
    logic [BYTE_W-1:0]     byte_value;
    logic [LEN_W-1:0]      position;
    logic [ERR_W-1:0]      fault_code;

    // Predictor copy of the codes and the frame state.
    logic [BYTE_W-1:0]     start_c;
    logic [BYTE_W-1:0]     end_c;
    logic [BYTE_W-1:0]     esc_c;
    bit                    frm_open;
    bit                    esc_armed;
    hdr_phase_t            hdr;
    logic [HALF_W-1:0]     len_hi;
    logic [LEN_W-1:0]      len_decl;
    logic [LEN_W-1:0]      pay_count;

    frame_res_t            res_due_q[$];
    dir_row_t              dir_tab[$];
    frame_res_t            want_res;
    int                    err_count;
    int                    results_seen;
    int                    cycle_count;
    bit                    no_idle;
    bit                    hold_done;
    int                    hold_left;

    escaped_frame_deframer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .byte_value (byte_value),
        .position   (position),
        .fault_code (fault_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicts the result of one accepted byte and advances the frame state.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] rx, output frame_res_t res);
        logic [BYTE_W-1:0] data;
        bit                was_open;
        res  = '0;
        data = rx;
        // The start code wins over the other codes and always opens a fresh frame.
        if (rx == start_c)
        begin
            was_open  = frm_open;
            frm_open  = 1'b1;
            hdr       = HDR_HIGH;
            pay_count = '0;
            esc_armed = 1'b0;
            if (was_open)
            begin
                res.kind       = KIND_ERR;
                res.fault_code = ERR_RESTART;
            end
            return was_open;
        end
        // The end code closes the frame whatever state it is in.
        if (rx == end_c)
        begin
            was_open = frm_open;
            frm_open = 1'b0;
            res.kind = KIND_ERR;
            if (!was_open)
                res.fault_code = ERR_STRAY_END;
            else if (hdr == HDR_PAYLOAD && pay_count == len_decl)
            begin
                res.kind     = KIND_DONE;
                res.position = len_decl;
            end
            else
                res.fault_code = ERR_EARLY_END;
            return 1'b1;
        end
        if (!frm_open)
        begin
            res.kind       = KIND_ERR;
            res.fault_code = ERR_OUTSIDE;
            return 1'b1;
        end
        // A second escape leaves the frame but keeps the flag set.
        if (rx == esc_c)
        begin
            if (esc_armed)
            begin
                frm_open       = 1'b0;
                res.kind       = KIND_ERR;
                res.fault_code = ERR_DOUBLE_ESCAPE;
                return 1'b1;
            end
            esc_armed = 1'b1;
            return 1'b0;
        end
        // Length header, seven bits per byte, high part first.
        if (hdr == HDR_HIGH)
        begin
            len_hi = rx[HALF_W-1:0];
            hdr    = HDR_LOW;
            return 1'b0;
        end
        if (hdr == HDR_LOW)
        begin
            len_decl = {len_hi, rx[HALF_W-1:0]};
            hdr      = HDR_PAYLOAD;
            return 1'b0;
        end
        // An escaped index selects one of the reserved bytes 253..255.
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            if (rx >= RESERVED_COUNT)
            begin
                frm_open       = 1'b0;
                res.kind       = KIND_ERR;
                res.fault_code = ERR_BAD_ESCAPE;
                return 1'b1;
            end
            data = 8'd253 + rx;
        end
        if (pay_count >= len_decl)
        begin
            frm_open       = 1'b0;
            res.kind       = KIND_ERR;
            res.fault_code = ERR_TOO_LONG;
            return 1'b1;
        end
        res.kind       = KIND_BYTE;
        res.byte_value = data;
        res.position   = pay_count;
        pay_count      = pay_count + 1'b1;
        return 1'b1;
    endfunction

    function automatic dir_row_t dir_row(input logic [BYTE_W-1:0] rx, input row_chk_t chk,
                                         input kind_t k, input err_t e,
                                         input logic [LEN_W-1:0] pos);
        dir_row_t row;
        row                = '0;
        row.rx             = rx;
        row.chk            = chk;
        row.res.kind       = k;
        row.res.fault_code = e;
        row.res.position   = pos;
        return row;
    endfunction

    // A random payload byte that matches none of the current codes.
    function automatic logic [BYTE_W-1:0] pick_data();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(0, 255));
        while (v == start_c || v == end_c || v == esc_c)
            v = BYTE_W'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("ERROR t=%0t %s: expected %0d, got %0d", $time, what, want, got);
        err_count++;
    endtask

    // Offers one item, waits for it to be taken, then records what it should produce.
    task automatic send_item(input logic [BYTE_W-1:0] b, input row_chk_t chk,
                             input frame_res_t fixed_res);
        frame_res_t pred;
        bit         has;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has = deframe_byte(b, pred);
        if (chk == ROW_FIXED)
            res_due_q.push_back(fixed_res);
        else if (chk == ROW_PRED && has)
            res_due_q.push_back(pred);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Lets every outstanding result come out, plus the pipeline depth.
    task automatic drain();
        in_valid <= 1'b0;
        while (res_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_START_CODE: start_c = val;
            CFG_END_CODE:   end_c   = val;
            default:        esc_c   = val;
        endcase
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] x);
        drain();
        write_reg(CFG_START_CODE, s);
        write_reg(CFG_END_CODE, e);
        write_reg(CFG_ESCAPE_CODE, x);
        cfg_we <= 1'b0;
    endtask

    // Random frames, mostly well formed, some broken on purpose, some noise between them.
    task automatic run_random(input int n_items);
        logic [BYTE_W-1:0] fr[$];
        logic [LEN_W-1:0]  lenv;
        int                sent;
        int                npay;
        int                m;
        int                i;
        sent = 0;
        while (sent < n_items)
        begin
            fr.delete();
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) fr.push_back(BYTE_W'($urandom_range(0, 255)));
            // Mostly short lengths; now and then a long one that ends early.
            if ($urandom_range(0, 11) == 0)
                lenv = LEN_W'($urandom_range(0, 16383));
            else
                lenv = LEN_W'($urandom_range(0, 12));
            npay = (lenv > 14) ? $urandom_range(0, 14) : int'(lenv);
            fr.push_back(start_c);
            fr.push_back({$urandom_range(0, 1) == 1, lenv[LEN_W-1:HALF_W]});
            fr.push_back({$urandom_range(0, 1) == 1, lenv[HALF_W-1:0]});
            for (i = 0; i < npay; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    fr.push_back(esc_c);
                    fr.push_back(BYTE_W'($urandom_range(0, 2)));
                end
                else
                    fr.push_back(pick_data());
            end
            fr.push_back(end_c);
            // Break some frames in the ways a noisy link would.
            m = $urandom_range(0, 11);
            case (m)
                0: fr[$urandom_range(0, fr.size() - 1)] = BYTE_W'($urandom_range(0, 255));
                1: fr.insert(fr.size() - 1, pick_data());
                2: fr.delete(fr.size() - 1);
                3: fr.insert($urandom_range(1, fr.size() - 1), esc_c);
                4: fr.delete(0);
                default: ;
            endcase
            foreach (fr[i])
                send_item(fr[i], ROW_PRED, '0);
            sent += fr.size();
        end
    endtask

    // Output checker: every taken result must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (res_due_q.size() == 0)
                report_mismatch("result with nothing expected, kind", -1, kind);
            else
            begin
                want_res = res_due_q.pop_front();
                if (kind != want_res.kind)
                    report_mismatch("kind", want_res.kind, kind);
                if (byte_value != want_res.byte_value)
                    report_mismatch("byte_value", want_res.byte_value, byte_value);
                if (position != want_res.position)
                    report_mismatch("position", want_res.position, position);
                if (fault_code != want_res.fault_code)
                    report_mismatch("fault_code", want_res.fault_code, fault_code);
            end
            results_seen++;
        end
    end

    // Receiver: random stall bursts, one long hold-off, no stalls in the last phase.
    initial
    begin
        hold_done = 1'b0;
        forever
        begin
            if (!hold_done && results_seen >= 30)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
                hold_done = 1'b1;
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        rx_byte      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        err_count    = 0;
        results_seen = 0;
        no_idle      = 1'b0;
        start_c      = START_CODE_RST;
        end_c        = END_CODE_RST;
        esc_c        = ESCAPE_CODE_RST;
        frm_open     = 1'b0;
        esc_armed    = 1'b0;
        hdr          = HDR_HIGH;
        len_hi       = '0;
        len_decl     = '0;
        pay_count    = '0;

        // Directed stream under the default codes (start 254, end 255, escape 253).
        dir_tab.push_back(dir_row(8'h00, ROW_FIXED, KIND_ERR,  ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFF, ROW_FIXED, KIND_ERR,  ERR_STRAY_END,     '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_NONE,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFF, ROW_FIXED, KIND_ERR,  ERR_EARLY_END,     '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_NONE,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFD, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h80, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h82, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h02, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h7F, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h10, ROW_FIXED, KIND_ERR,  ERR_TOO_LONG,      '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_NONE,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h7F, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h7F, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_FIXED, KIND_ERR,  ERR_RESTART,       '0));
        dir_tab.push_back(dir_row(8'h80, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h00, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFF, ROW_FIXED, KIND_DONE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_NONE,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h00, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h01, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFD, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'h03, ROW_FIXED, KIND_ERR,  ERR_BAD_ESCAPE,    '0));
        dir_tab.push_back(dir_row(8'hFE, ROW_NONE,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFD, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));
        dir_tab.push_back(dir_row(8'hFD, ROW_FIXED, KIND_ERR,  ERR_DOUBLE_ESCAPE, '0));
        dir_tab.push_back(dir_row(8'hFC, ROW_PRED,  KIND_BYTE, ERR_OUTSIDE,       '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].rx, dir_tab[i].chk, dir_tab[i].res);
        run_random(150);

        // Codes at the extremes of the byte range.
        set_codes(8'h00, 8'hFF, 8'h80);
        run_random(100);
        set_codes(8'hFF, 8'h00, 8'h01);
        run_random(100);

        // All three codes equal: the start code takes priority.
        set_codes(8'h55, 8'h55, 8'h55);
        run_random(40);

        // End and escape equal: the end code takes priority.
        set_codes(8'h01, 8'h02, 8'h02);
        run_random(60);

        // Back to the defaults, with neither side idling.
        set_codes(START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
        no_idle = 1'b1;
        run_random(100);
        drain();

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/efd_pkg.sv
rtl/efd_front.sv
rtl/efd_queue.sv
rtl/efd_back.sv
rtl/escaped_frame_deframer.sv
dv/tb_top.sv
